// ===== design/mao_pkg.sv =====
// Package for the mark attachment offset block: types, codes and constants.
`timescale 1ns / 1ps
package mao_pkg;

    localparam int DEF_FONT_BYTES = 262144;
    // Exact address arithmetic: base array cells reach beyond 2^34.
    localparam int ADDR_W = 36;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 19;
    localparam int OFS_W = 17;

    typedef logic [ADDR_W-1:0] t_addr;

    localparam logic [CFG_IDX_W-1:0] CFG_FACE_VALID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LOOKUP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MM_LOOKUP   = 2'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] COV_FMT_LIST  = 2'd1;
    localparam logic [1:0] COV_FMT_RANGE = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE, S_RD0, S_RD1, S_RD2,
        S_SUBS, S_SLOOP, S_SUB, S_FMT, S_F2, S_F4, S_F6, S_F8, S_F10, S_NEXT,
        S_CV, S_CVF, S_CVC, S_B1, S_B2, S_R1, S_R2, S_R3, S_R4, S_CVRES,
        S_MR, S_MR1, S_MR2, S_MR3, S_MR4, S_MR5,
        S_BA1, S_BA2, S_BA3, S_BA4, S_BA5, S_DONE
    } t_state;

    function automatic t_addr ext16(input logic [15:0] v);
        return t_addr'(v);
    endfunction

endpackage

// ===== design/mao_if.sv =====
// Channel interfaces: input items, results and configuration writes.
`timescale 1ns / 1ps
interface mao_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [17:0] byte_address;
    logic [7:0]  byte_value;
    logic [15:0] base_glyph;
    logic [15:0] mark_glyph;
    logic        base_is_mark;
    modport source (output valid, op, byte_address, byte_value, base_glyph, mark_glyph,
                    base_is_mark, input ready);
    modport sink (input valid, op, byte_address, byte_value, base_glyph, mark_glyph,
                  base_is_mark, output ready);
endinterface

interface mao_res_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic signed [16:0] offset_x;
    logic signed [16:0] offset_y;
    modport source (output valid, found, offset_x, offset_y, input ready);
    modport sink (input valid, found, offset_x, offset_y, output ready);
endinterface

interface mao_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [18:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/mao_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module mao_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== design/mark_attachment_offset_top.sv =====
// Top level: font byte store and GPOS mark attachment walk sequencer.
//
// Usage. Three channels, valid/ready, a beat moves when both are high.
//   i_item: op=load writes byte_value at byte_address (ignored at or beyond
//           FONT_BYTES), no result. op=query looks up base_glyph/mark_glyph in
//           the MarkBase (base_is_mark=0) or MarkMark lookup.
//   o_res : one beat per query: found, offset_x, offset_y (zero if not found).
//   i_cfg : register writes, always ready; write only while no query is in flight.
// Loads are accepted only while the sequencer is idle. A query runs on one
// sequencer around a single font memory read port; every 16-bit field is
// fetched in steps (issue, two byte reads through the registered RAM, capture).
// A query that fails the register checks goes straight to its result;
// otherwise the walk reads the lookup header, then per subtable its header,
// each coverage table (binary search for a glyph list, linear scan for range
// records), and the mark record and both anchors.
// Reset clears control and registers (offsets to absent); font memory is not
// cleared. A finished result waits in an output register; loads are accepted
// meanwhile, and a further query holds its result until the register frees.
`timescale 1ns / 1ps
module mark_attachment_offset_top
    import mao_pkg::*;
#(
    parameter int FONT_BYTES = DEF_FONT_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mao_item_if.sink    i_item,
    mao_res_if.source   o_res,
    mao_cfg_if.sink     i_cfg
);
    localparam int AW = $clog2(FONT_BYTES);
    localparam t_addr FB = t_addr'(FONT_BYTES);

    t_state r_state, n_state, r_ret, n_ret;
    t_addr  r_fa, n_fa;
    logic [7:0]  r_hi, n_hi;
    logic [15:0] r_word, n_word;

    logic        r_face_valid;
    logic [18:0] r_data_length, r_base_lk, r_mm_lk;

    logic [15:0] r_base, n_base, r_mark, n_mark;
    t_addr r_lk, n_lk, r_sub, n_sub, r_mcov, n_mcov, r_bcov, n_bcov;
    t_addr r_marr, n_marr, r_barr, n_barr, r_cov, n_cov, r_rr, n_rr, r_anc, n_anc;
    logic [15:0] r_subs, n_subs, r_s, n_s, r_classes, n_classes;
    logic [15:0] r_glyph, n_glyph, r_cfmt, n_cfmt, r_count, n_count;
    logic [15:0] r_first, n_first, r_cls, n_cls;
    logic signed [17:0] r_lo, n_lo, r_hi_b, n_hi_b;
    logic [15:0] r_mid, n_mid;
    logic [15:0] r_i, n_i;
    logic        r_which, n_which, r_cv_ok, n_cv_ok;
    logic [16:0] r_idx, n_idx, r_mi, n_mi, r_bi, n_bi;
    logic [15:0] r_mx, n_mx, r_my, n_my, r_bx, n_bx;
    logic [32:0] r_prod, n_prod;
    logic        r_found, n_found;
    logic signed [16:0] r_dx, n_dx, r_dy, n_dy;
    logic        r_ovalid, n_ovalid, r_ofound, n_ofound;
    logic signed [16:0] r_ox, n_ox, r_oy, n_oy;

    t_addr n_lim, ea, ra, ca, aa;
    logic signed [17:0] sum_lh;
    logic [18:0] sel_lk;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;
    t_addr         load_a;

    assign n_lim  = (t_addr'(r_data_length) > FB) ? FB : t_addr'(r_data_length);
    assign load_a = t_addr'(i_item.byte_address);
    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_res.valid    = r_ovalid;
    assign o_res.found    = r_ofound;
    assign o_res.offset_x = r_ox;
    assign o_res.offset_y = r_oy;

    assign ram_we = i_item.valid && i_item.ready && (i_item.op == OP_LOAD) && (load_a < FB);

    always_comb begin
        if (r_state == S_RD1) ram_addr = AW'(r_fa + t_addr'(1));
        else if (r_state == S_IDLE) ram_addr = load_a[AW-1:0];
        else ram_addr = r_fa[AW-1:0];
    end

    mao_ram #(.WIDTH(8), .DEPTH(FONT_BYTES)) u_font (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_item.byte_value),
        .o_rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_valid  <= 1'b0;
            r_data_length <= '0;
            r_base_lk     <= '1;
            r_mm_lk       <= '1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_FACE_VALID:  r_face_valid  <= i_cfg.data[0];
                CFG_DATA_LENGTH: r_data_length <= i_cfg.data;
                CFG_BASE_LOOKUP: r_base_lk     <= i_cfg.data;
                CFG_MM_LOOKUP:   r_mm_lk       <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_ovalid <= n_ovalid;
        end
        r_fa <= n_fa; r_hi <= n_hi; r_word <= n_word;
        r_base <= n_base; r_mark <= n_mark; r_lk <= n_lk; r_sub <= n_sub;
        r_mcov <= n_mcov; r_bcov <= n_bcov; r_marr <= n_marr; r_barr <= n_barr;
        r_cov <= n_cov; r_rr <= n_rr; r_anc <= n_anc;
        r_subs <= n_subs; r_s <= n_s; r_classes <= n_classes;
        r_glyph <= n_glyph; r_cfmt <= n_cfmt; r_count <= n_count;
        r_first <= n_first; r_cls <= n_cls; r_lo <= n_lo; r_hi_b <= n_hi_b;
        r_mid <= n_mid; r_i <= n_i; r_which <= n_which; r_cv_ok <= n_cv_ok;
        r_idx <= n_idx; r_mi <= n_mi; r_bi <= n_bi;
        r_mx <= n_mx; r_my <= n_my; r_bx <= n_bx; r_prod <= n_prod;
        r_found <= n_found; r_dx <= n_dx; r_dy <= n_dy;
        r_ofound <= n_ofound; r_ox <= n_ox; r_oy <= n_oy;
    end

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_fa = r_fa; n_hi = r_hi; n_word = r_word;
        n_base = r_base; n_mark = r_mark; n_lk = r_lk; n_sub = r_sub;
        n_mcov = r_mcov; n_bcov = r_bcov; n_marr = r_marr; n_barr = r_barr;
        n_cov = r_cov; n_rr = r_rr; n_anc = r_anc;
        n_subs = r_subs; n_s = r_s; n_classes = r_classes;
        n_glyph = r_glyph; n_cfmt = r_cfmt; n_count = r_count;
        n_first = r_first; n_cls = r_cls; n_lo = r_lo; n_hi_b = r_hi_b;
        n_mid = r_mid; n_i = r_i; n_which = r_which; n_cv_ok = r_cv_ok;
        n_idx = r_idx; n_mi = r_mi; n_bi = r_bi;
        n_mx = r_mx; n_my = r_my; n_bx = r_bx; n_prod = r_prod;
        n_found = r_found; n_dx = r_dx; n_dy = r_dy;
        n_ovalid = r_ovalid && !o_res.ready;
        n_ofound = r_ofound; n_ox = r_ox; n_oy = r_oy;

        sel_lk = i_item.base_is_mark ? r_mm_lk : r_base_lk;
        sum_lh = r_lo + r_hi_b;
        ea = r_cov + t_addr'(4) + (ext16(r_mid) << 1);
        ra = r_cov + t_addr'(4) + (ext16(r_i) << 2) + (ext16(r_i) << 1);
        ca = r_barr + t_addr'(2) + (t_addr'(r_prod) << 1) + (ext16(r_cls) << 1);
        aa = (r_state == S_MR3 ? r_marr : r_barr) + ext16(r_word);

        case (r_state)
            S_IDLE: begin
                if (i_item.valid && i_item.op == OP_QUERY) begin
                    n_base = i_item.base_glyph;
                    n_mark = i_item.mark_glyph;
                    n_lk   = t_addr'(sel_lk);
                    n_found = 1'b0; n_dx = '0; n_dy = '0;
                    if (!r_face_valid || sel_lk[18] || n_lim == '0 ||
                        t_addr'(sel_lk) + t_addr'(6) > n_lim) begin
                        n_state = S_DONE;
                    end else begin
                        n_fa = t_addr'(sel_lk) + t_addr'(4); n_ret = S_SUBS; n_state = S_RD0;
                    end
                end
            end
            // 16-bit big-endian fetch through the registered read port
            S_RD0: n_state = S_RD1;
            S_RD1: begin
                n_hi = ram_rdata;
                n_state = S_RD2;
            end
            S_RD2: begin
                n_word = {r_hi, ram_rdata};
                n_state = r_ret;
            end
            S_SUBS: begin
                n_subs = r_word; n_s = '0; n_state = S_SLOOP;
            end
            S_SLOOP: begin
                if (r_s >= r_subs ||
                    r_lk + t_addr'(8) + (ext16(r_s) << 1) > n_lim) begin
                    n_state = S_DONE;
                end else begin
                    n_fa = r_lk + t_addr'(6) + (ext16(r_s) << 1); n_ret = S_SUB;
                    n_state = S_RD0;
                end
            end
            S_SUB: begin
                n_sub = r_lk + ext16(r_word);
                if (r_lk + ext16(r_word) + t_addr'(12) > n_lim) n_state = S_NEXT;
                else begin
                    n_fa = r_lk + ext16(r_word); n_ret = S_FMT; n_state = S_RD0;
                end
            end
            S_FMT: begin
                if (r_word != 16'd1) n_state = S_NEXT;
                else begin
                    n_fa = r_sub + t_addr'(2); n_ret = S_F2; n_state = S_RD0;
                end
            end
            S_F2: begin
                n_mcov = r_sub + ext16(r_word);
                n_fa = r_sub + t_addr'(4); n_ret = S_F4; n_state = S_RD0;
            end
            S_F4: begin
                n_bcov = r_sub + ext16(r_word);
                n_fa = r_sub + t_addr'(6); n_ret = S_F6; n_state = S_RD0;
            end
            S_F6: begin
                n_classes = r_word;
                n_fa = r_sub + t_addr'(8); n_ret = S_F8; n_state = S_RD0;
            end
            S_F8: begin
                n_marr = r_sub + ext16(r_word);
                n_fa = r_sub + t_addr'(10); n_ret = S_F10; n_state = S_RD0;
            end
            S_F10: begin
                n_barr = r_sub + ext16(r_word);
                if (r_classes == '0) n_state = S_NEXT;
                else begin
                    n_cov = r_mcov; n_glyph = r_mark; n_which = 1'b0; n_state = S_CV;
                end
            end
            S_NEXT: begin
                n_s = r_s + 16'd1; n_state = S_SLOOP;
            end
            // coverage lookup, shared for mark and base
            S_CV: begin
                n_cv_ok = 1'b0;
                if (r_cov == '0 || r_cov + t_addr'(4) > n_lim) n_state = S_CVRES;
                else begin
                    n_fa = r_cov; n_ret = S_CVF; n_state = S_RD0;
                end
            end
            S_CVF: begin
                n_cfmt = r_word;
                n_fa = r_cov + t_addr'(2); n_ret = S_CVC; n_state = S_RD0;
            end
            S_CVC: begin
                n_count = r_word;
                n_lo = '0;
                n_hi_b = $signed({2'b00, r_word}) - 18'sd1;
                n_i = '0;
                if (r_cfmt == 16'(COV_FMT_LIST)) n_state = S_B1;
                else if (r_cfmt == 16'(COV_FMT_RANGE)) n_state = S_R1;
                else n_state = S_CVRES;
            end
            S_B1: begin
                if (r_lo > r_hi_b) n_state = S_CVRES;
                else begin
                    n_mid = sum_lh[16:1];
                    n_state = S_B2;
                    n_ret = S_B2;
                end
                // mid is settled; S_R4 checks the entry address before the fetch for B2
                if (r_lo <= r_hi_b) begin
                    n_state = S_R4;
                    n_ret = S_B2;
                end
            end
            S_R4: begin
                if (r_cfmt == 16'(COV_FMT_RANGE)) begin
                    n_idx = {1'b0, r_word} + {1'b0, r_glyph - r_first};
                    n_cv_ok = 1'b1;
                    n_state = S_CVRES;
                end else if (ea + t_addr'(2) > n_lim) begin
                    n_state = S_CVRES;
                end else begin
                    n_fa = ea; n_ret = S_B2; n_state = S_RD0;
                end
            end
            S_B2: begin
                if (r_word == r_glyph) begin
                    n_idx = {1'b0, r_mid}; n_cv_ok = 1'b1; n_state = S_CVRES;
                end else begin
                    if (r_word < r_glyph) n_lo = $signed({2'b00, r_mid}) + 18'sd1;
                    else n_hi_b = $signed({2'b00, r_mid}) - 18'sd1;
                    n_state = S_B1;
                end
            end
            S_R1: begin
                if (r_i >= r_count || ra + t_addr'(6) > n_lim) n_state = S_CVRES;
                else begin
                    n_rr = ra; n_fa = ra; n_ret = S_R2; n_state = S_RD0;
                end
            end
            S_R2: begin
                n_first = r_word;
                n_fa = r_rr + t_addr'(2); n_ret = S_R3; n_state = S_RD0;
            end
            S_R3: begin
                if (r_glyph >= r_first && r_glyph <= r_word) begin
                    n_fa = r_rr + t_addr'(4); n_ret = S_R4; n_state = S_RD0;
                end else begin
                    n_i = r_i + 16'd1; n_state = S_R1;
                end
            end
            S_CVRES: begin
                if (!r_cv_ok) n_state = S_NEXT;
                else if (!r_which) begin
                    n_mi = r_idx; n_cov = r_bcov; n_glyph = r_base; n_which = 1'b1;
                    n_state = S_CV;
                end else begin
                    n_bi = r_idx; n_state = S_MR;
                end
            end
            // mark record and anchor
            S_MR: begin
                if (r_marr == '0 || r_marr + t_addr'(2) > n_lim) n_state = S_NEXT;
                else begin
                    n_fa = r_marr; n_ret = S_MR1; n_state = S_RD0;
                end
            end
            S_MR1: begin
                n_rr = r_marr + t_addr'(2) + (t_addr'(r_mi) << 2);
                if (r_mi >= {1'b0, r_word} ||
                    r_marr + t_addr'(6) + (t_addr'(r_mi) << 2) > n_lim) n_state = S_NEXT;
                else begin
                    n_fa = r_marr + t_addr'(2) + (t_addr'(r_mi) << 2); n_ret = S_MR2;
                    n_state = S_RD0;
                end
            end
            S_MR2: begin
                n_cls = r_word;
                n_fa = r_rr + t_addr'(2); n_ret = S_MR3; n_state = S_RD0;
            end
            S_MR3: begin
                n_anc = aa;
                if (r_word == '0 || aa + t_addr'(6) > n_lim) n_state = S_NEXT;
                else begin
                    n_fa = aa + t_addr'(2); n_ret = S_MR4; n_state = S_RD0;
                end
            end
            S_MR4: begin
                n_mx = r_word;
                n_fa = r_anc + t_addr'(4); n_ret = S_MR5; n_state = S_RD0;
            end
            S_MR5: begin
                n_my = r_word;
                if (r_cls >= r_classes || r_barr + t_addr'(2) > n_lim) n_state = S_NEXT;
                else begin
                    n_fa = r_barr; n_ret = S_BA1; n_state = S_RD0;
                end
            end
            // base anchor cell: row bi, column cls
            S_BA1: begin
                n_prod = r_bi * r_classes;
                if (r_bi >= {1'b0, r_word}) n_state = S_NEXT;
                else n_state = S_BA2;
            end
            S_BA2: begin
                if (ca + t_addr'(2) > n_lim) n_state = S_NEXT;
                else begin
                    n_fa = ca; n_ret = S_BA3; n_state = S_RD0;
                end
            end
            S_BA3: begin
                n_anc = aa;
                if (r_word == '0 || aa + t_addr'(6) > n_lim) n_state = S_NEXT;
                else begin
                    n_fa = aa + t_addr'(2); n_ret = S_BA4; n_state = S_RD0;
                end
            end
            S_BA4: begin
                n_bx = r_word;
                n_fa = r_anc + t_addr'(4); n_ret = S_BA5; n_state = S_RD0;
            end
            S_BA5: begin
                n_found = 1'b1;
                n_dx = $signed({r_bx[15], r_bx}) - $signed({r_mx[15], r_mx});
                n_dy = $signed({r_word[15], r_word}) - $signed({r_my[15], r_my});
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid = 1'b1;
                    n_ofound = r_found; n_ox = r_dx; n_oy = r_dy;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_rd_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD1) |-> ($past(r_state) == S_RD0))
        else $error("byte fetch out of sequence");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_res.ready) |=> (r_ovalid && $stable(r_ox) && $stable(r_oy)))
        else $error("pending result lost");
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_ofound) |-> (r_ox == '0 && r_oy == '0))
        else $error("not-found result carries an offset");
    a_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE && !(r_ret == S_RD0)))
        else $error("font write during a walk");
endmodule

// ===== dv/tb_top.sv =====
// Testbench for the mark attachment block: builds small GPOS lookups, queries them, checks results.
`timescale 1ns / 1ps
module tb_top;
    import mao_pkg::*;

    localparam int NFONT    = 262144;
    localparam int LK_BASE  = 'h0100;
    localparam int LK_MM    = 'h2000;
    localparam int WD_LIMIT = 50000;
    localparam int NPHASE   = 10;

    typedef struct {
        logic        op;
        logic [17:0] addr;
        logic [7:0]  val;
        logic [15:0] base;
        logic [15:0] mark;
        logic        bim;
    } t_item;

    typedef struct {
        logic               found;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
    } t_attach;

    logic i_clk;
    logic i_rst_n;

    mao_item_if itm();
    mao_res_if  res();
    mao_cfg_if  cfg();

    mark_attachment_offset_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (itm),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    // mirror of the font memory and the registers
    logic [7:0]  font_img [NFONT];
    logic        cfg_face;
    logic [18:0] cfg_len;
    logic [18:0] cfg_base_lk;
    logic [18:0] cfg_mm_lk;

    t_item   pend_q[$];
    t_attach attach_q[$];
    int      mb_marks[$], mb_bases[$], mm_marks[$], mm_bases[$];
    int      wp;
    bit      calm;
    int      errs, n_items, n_queries, n_hits, wd;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------- prediction ----------------
    function automatic longint lim();
        return (cfg_len > NFONT) ? longint'(NFONT) : longint'(cfg_len);
    endfunction

    function automatic longint rd8(longint a);
        return (a < NFONT) ? longint'(font_img[a]) : 0;
    endfunction

    function automatic longint rd16(longint a);
        return (rd8(a) << 8) | rd8(a + 1);
    endfunction

    function automatic int rds16(longint a);
        logic signed [15:0] v;
        v = 16'(rd16(a));
        return v;
    endfunction

    function automatic longint cover_idx(longint cov, longint glyph);
        longint n, cnt, lo, hi, mid, e, g, r, first, last, i;
        n = lim();
        if (cov == 0 || cov + 4 > n) return -1;
        cnt = rd16(cov + 2);
        if (rd16(cov) == COV_FMT_LIST) begin
            lo = 0;
            hi = cnt - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                e = cov + 4 + mid * 2;
                if (e + 2 > n) return -1;
                g = rd16(e);
                if (g == glyph) return mid;
                if (g < glyph) lo = mid + 1;
                else hi = mid - 1;
            end
            return -1;
        end
        if (rd16(cov) == COV_FMT_RANGE) begin
            for (i = 0; i < cnt; i++) begin
                r = cov + 4 + i * 6;
                if (r + 6 > n) break;
                first = rd16(r);
                last = rd16(r + 2);
                if (glyph >= first && glyph <= last) return rd16(r + 4) + (glyph - first);
            end
        end
        return -1;
    endfunction

    function automatic bit anchor_at(longint a, output int x, output int y);
        x = 0;
        y = 0;
        if (a == 0 || a + 6 > lim()) return 0;
        x = rds16(a + 2);
        y = rds16(a + 4);
        return 1;
    endfunction

    function automatic bit mark_entry(longint arr, longint idx, output longint cls,
                                      output int x, output int y);
        longint n, rec, anc;
        n = lim();
        cls = 0;
        x = 0;
        y = 0;
        if (arr == 0 || arr + 2 > n) return 0;
        if (idx < 0 || idx >= rd16(arr)) return 0;
        rec = arr + 2 + idx * 4;
        if (rec + 4 > n) return 0;
        cls = rd16(rec);
        anc = rd16(rec + 2);
        if (anc == 0) return 0;
        return anchor_at(arr + anc, x, y);
    endfunction

    function automatic t_attach predict_attach(logic [15:0] bg, logic [15:0] mg, logic bim);
        t_attach r;
        logic [18:0] lkr;
        longint n, lk, s, subs, so, sub, mcov, bcov, classes, marr, barr, mi, bi, cls, slot, anc;
        int mx, my, bx, by;
        r.found = 1'b0;
        r.dx = '0;
        r.dy = '0;
        lkr = bim ? cfg_mm_lk : cfg_base_lk;
        n = lim();
        if (!cfg_face || lkr[18] || n == 0) return r;
        lk = lkr;
        if (lk + 6 > n) return r;
        subs = rd16(lk + 4);
        for (s = 0; s < subs; s++) begin
            so = lk + 6 + s * 2;
            if (so + 2 > n) break;
            sub = lk + rd16(so);
            if (sub + 12 > n) continue;
            if (rd16(sub) != 1) continue;
            mcov = sub + rd16(sub + 2);
            bcov = sub + rd16(sub + 4);
            classes = rd16(sub + 6);
            marr = sub + rd16(sub + 8);
            barr = sub + rd16(sub + 10);
            if (classes <= 0) continue;
            mi = cover_idx(mcov, mg);
            bi = cover_idx(bcov, bg);
            if (mi < 0 || bi < 0) continue;
            if (!mark_entry(marr, mi, cls, mx, my)) continue;
            if (cls < 0 || cls >= classes) continue;
            if (barr + 2 > n) continue;
            if (bi >= rd16(barr)) continue;
            slot = barr + 2 + bi * classes * 2 + cls * 2;
            if (slot + 2 > n) continue;
            anc = rd16(slot);
            if (anc == 0) continue;
            if (!anchor_at(barr + anc, bx, by)) continue;
            r.found = 1'b1;
            r.dx = 17'(bx - mx);
            r.dy = 17'(by - my);
            return r;
        end
        return r;
    endfunction

    // ---------------- item driver ----------------
    always @(posedge i_clk) begin : drv
        t_item t;
        int gap;
        if (!i_rst_n) begin
            itm.valid <= 1'b0;
            gap = 0;
        end else begin
            if (itm.valid && itm.ready) begin
                n_items++;
                if (itm.op == OP_LOAD) begin
                    font_img[itm.byte_address] = itm.byte_value;
                end else begin
                    attach_q.insert(attach_q.size(),
                                    predict_attach(itm.base_glyph, itm.mark_glyph,
                                                   itm.base_is_mark));
                    n_queries++;
                end
            end
            if (itm.valid && !itm.ready) begin
                // hold the beat until taken
            end else if (gap > 0) begin
                gap--;
                itm.valid <= 1'b0;
            end else if (pend_q.size() != 0 && !calm && $urandom_range(0, 15) == 0) begin
                gap = $urandom_range(1, 19) - 1;
                itm.valid <= 1'b0;
            end else if (pend_q.size() != 0) begin
                t = pend_q.pop_front();
                itm.valid        <= 1'b1;
                itm.op           <= t.op;
                itm.byte_address <= t.addr;
                itm.byte_value   <= t.val;
                itm.base_glyph   <= t.base;
                itm.mark_glyph   <= t.mark;
                itm.base_is_mark <= t.bim;
            end else begin
                itm.valid <= 1'b0;
            end
        end
    end

    // ---------------- result monitor ----------------
    always @(posedge i_clk) begin : mon
        t_attach e;
        int stall;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            stall = 0;
        end else begin
            if (res.valid && res.ready) begin
                if (attach_q.size() == 0) begin
                    $error("result beat with no query outstanding");
                    errs++;
                end else begin
                    e = attach_q.pop_front();
                    if (e.found) n_hits++;
                    if (res.found !== e.found) begin
                        $error("found: expected %0d, got %0d", e.found, res.found);
                        errs++;
                    end
                    if (res.offset_x !== e.dx) begin
                        $error("offset_x: expected %0d, got %0d", e.dx, res.offset_x);
                        errs++;
                    end
                    if (res.offset_y !== e.dy) begin
                        $error("offset_y: expected %0d, got %0d", e.dy, res.offset_y);
                        errs++;
                    end
                end
            end
            if (stall > 0) begin
                stall--;
                res.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                stall = $urandom_range(1, 19) - 1;
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if ((itm.valid && itm.ready) || (res.valid && res.ready) || !i_rst_n) begin
            wd <= 0;
        end else if (wd >= WD_LIMIT) begin
            $display("stalled for %0d cycles with %0d results outstanding", wd, attach_q.size());
            $display("tb_top NOT OK");
            $finish;
        end else begin
            wd <= wd + 1;
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic put8(input int a, input int v);
        t_item t;
        t.op = OP_LOAD;
        t.addr = 18'(a);
        t.val = 8'(v);
        t.base = 16'($urandom);
        t.mark = 16'($urandom);
        t.bim = 1'($urandom);
        pend_q.insert(pend_q.size(), t);
    endtask

    task automatic put16(input int a, input int v);
        put8(a, (v >> 8) & 'hFF);
        put8(a + 1, v & 'hFF);
    endtask

    task automatic push_query(input int bg, input int mg, input bit bim);
        t_item t;
        t.op = OP_QUERY;
        t.addr = 18'($urandom);
        t.val = 8'($urandom);
        t.base = 16'(bg);
        t.mark = 16'(mg);
        t.bim = bim;
        pend_q.insert(pend_q.size(), t);
    endtask

    function automatic int coord();
        case ($urandom_range(0, 5))
            0: return 'h8000;
            1: return 'h7FFF;
            2: return 0;
            3: return 'hFFFF;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic put_anchor(input int a);
        put16(a, 1);
        put16(a + 2, coord());
        put16(a + 4, coord());
    endtask

    task automatic add_glyph(input bit bim, input bit is_mark, input int g);
        if (bim) begin
            if (is_mark) mm_marks.insert(mm_marks.size(), g);
            else mm_bases.insert(mm_bases.size(), g);
        end else begin
            if (is_mark) mb_marks.insert(mb_marks.size(), g);
            else mb_bases.insert(mb_bases.size(), g);
        end
    endtask

    // coverage of n glyphs at wp, as a sorted list or as one or two ranges
    task automatic make_cov(input bit bim, input bit is_mark, input int n);
        int g[$];
        int hit[$];
        int at, v, k, g0, g1, i;
        at = wp;
        if ($urandom_range(0, 1)) begin
            while (g.size() < n) begin
                v = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 0 : 65535)
                                                : $urandom_range(0, 65535);
                hit = g.find_first_index(x) with (x == v);
                if (hit.size() == 0) g.insert(g.size(), v);
            end
            g.sort();
            put16(at, COV_FMT_LIST);
            put16(at + 2, g.size());
            foreach (g[j]) put16(at + 4 + 2 * j, g[j]);
            wp = at + 4 + 2 * g.size();
        end else begin
            k = $urandom_range(1, n);
            g0 = $urandom_range(0, 65536 - k);
            put16(at, COV_FMT_RANGE);
            put16(at + 2, (n > k) ? 2 : 1);
            put16(at + 4, g0);
            put16(at + 6, g0 + k - 1);
            put16(at + 8, 0);
            for (i = 0; i < k; i++) g.insert(g.size(), g0 + i);
            wp = at + 10;
            if (n > k) begin
                g1 = $urandom_range(0, 65536 - (n - k));
                put16(at + 10, g1);
                put16(at + 12, g1 + n - k - 1);
                put16(at + 14, k);
                for (i = 0; i < n - k; i++) g.insert(g.size(), g1 + i);
                wp = at + 16;
            end
        end
        foreach (g[j]) add_glyph(bim, is_mark, g[j]);
    endtask

    // one subtable; some come out deliberately broken in one way
    task automatic make_sub(input int s, input bit bim);
        int flaw, nm, nb, ncls, mcov, bcov, marr, barr, anc, i;
        flaw = $urandom_range(0, 11);
        nm = $urandom_range(1, 4);
        nb = $urandom_range(1, 4);
        ncls = $urandom_range(1, 3);
        wp = s + 12;
        mcov = wp;
        make_cov(bim, 1'b1, nm);
        bcov = wp;
        make_cov(bim, 1'b0, nb);
        marr = wp;
        put16(marr, (flaw == 2) ? nm - 1 : nm);
        anc = 2 + 4 * nm;
        for (i = 0; i < nm; i++) begin
            put16(marr + 2 + 4 * i, (flaw == 3 && i == 0) ? ncls : $urandom_range(0, ncls - 1));
            put16(marr + 4 + 4 * i, (flaw == 4 && i == 0) ? 0 : anc + 6 * i);
            put_anchor(marr + anc + 6 * i);
        end
        barr = marr + anc + 6 * nm;
        put16(barr, nb);
        anc = 2 + 2 * nb * ncls;
        for (i = 0; i < nb * ncls; i++) begin
            put16(barr + 2 + 2 * i, (flaw == 5 && i == 0) ? 0 : anc + 6 * i);
            put_anchor(barr + anc + 6 * i);
        end
        wp = barr + anc + 6 * nb * ncls;
        put16(s, (flaw == 0) ? 2 : 1);
        put16(s + 2, mcov - s);
        put16(s + 4, bcov - s);
        put16(s + 6, (flaw == 1) ? 0 : ncls);
        put16(s + 8, marr - s);
        put16(s + 10, barr - s);
    endtask

    task automatic make_lookup(input int lk, input bit bim);
        int nsub, s;
        if (bim) begin
            mm_marks.delete();
            mm_bases.delete();
        end else begin
            mb_marks.delete();
            mb_bases.delete();
        end
        nsub = $urandom_range(1, 3);
        put16(lk, bim ? 6 : 4);
        put16(lk + 2, 0);
        put16(lk + 4, nsub);
        wp = lk + 6 + 2 * nsub;
        for (s = 0; s < nsub; s++) begin
            put16(lk + 6 + 2 * s, wp - lk);
            make_sub(wp, bim);
        end
    endtask

    function automatic int pick_glyph(input bit bim, input bit is_mark);
        int sz;
        sz = bim ? (is_mark ? mm_marks.size() : mm_bases.size())
                 : (is_mark ? mb_marks.size() : mb_bases.size());
        if (sz == 0) return $urandom_range(0, 65535);
        if (bim) return is_mark ? mm_marks[$urandom_range(0, sz - 1)]
                                : mm_bases[$urandom_range(0, sz - 1)];
        return is_mark ? mb_marks[$urandom_range(0, sz - 1)] : mb_bases[$urandom_range(0, sz - 1)];
    endfunction

    task automatic random_query();
        int r;
        bit bim;
        bim = $urandom_range(0, 1);
        r = $urandom_range(0, 9);
        if (r < 7) push_query(pick_glyph(bim, 1'b0), pick_glyph(bim, 1'b1), bim);
        else if (r == 7) push_query(pick_glyph(bim, 1'b0), $urandom_range(0, 65535), bim);
        else if (r == 8) push_query($urandom_range(0, 65535), pick_glyph(bim, 1'b1), bim);
        else push_query(pick_glyph(!bim, 1'b0), pick_glyph(!bim, 1'b1), bim);
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (pend_q.size() != 0 || itm.valid || attach_q.size() != 0) @(negedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [18:0] f, input logic [18:0] l,
                              input logic [18:0] b, input logic [18:0] m);
        logic [1:0]  ix [4];
        logic [18:0] v  [4];
        int i;
        ix[0] = CFG_FACE_VALID;
        ix[1] = CFG_DATA_LENGTH;
        ix[2] = CFG_BASE_LOOKUP;
        ix[3] = CFG_MM_LOOKUP;
        v[0] = f;
        v[1] = l;
        v[2] = b;
        v[3] = m;
        @(posedge i_clk);
        for (i = 0; i < 4; i++) begin
            cfg.valid <= 1'b1;
            cfg.index <= ix[i];
            cfg.data  <= v[i];
            do @(posedge i_clk); while (!cfg.ready);
            case (ix[i])
                CFG_FACE_VALID:  cfg_face = v[i][0];
                CFG_DATA_LENGTH: cfg_len = v[i];
                CFG_BASE_LOOKUP: cfg_base_lk = v[i];
                CFG_MM_LOOKUP:   cfg_mm_lk = v[i];
                default: ;
            endcase
        end
        cfg.valid <= 1'b0;
    endtask

    // ---------------- sequence ----------------
    initial begin
        int p, i;
        logic [18:0] f, l, b, m;
        i_rst_n = 1'b0;
        itm.valid = 1'b0;
        itm.op = OP_LOAD;
        itm.byte_address = '0;
        itm.byte_value = '0;
        itm.base_glyph = '0;
        itm.mark_glyph = '0;
        itm.base_is_mark = 1'b0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_FACE_VALID;
        cfg.data = '0;
        cfg_face = 1'b0;
        cfg_len = '0;
        cfg_base_lk = 19'h7FFFF;
        cfg_mm_lk = 19'h7FFFF;
        calm = 1'b0;
        errs = 0;
        n_items = 0;
        n_queries = 0;
        n_hits = 0;
        wd = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset values: nothing can attach
        @(negedge i_clk);
        push_query(0, 65535, 1'b0);
        push_query(65535, 0, 1'b1);
        // zero block at the bottom doubles as an empty lookup
        for (i = 0; i < LK_BASE; i++) put8(i, 0);
        make_lookup(LK_BASE, 1'b0);
        make_lookup(LK_MM, 1'b1);
        settle();

        for (p = 0; p < NPHASE; p++) begin
            f = 19'd1;
            l = 19'd262144;
            b = 19'(LK_BASE);
            m = 19'(LK_MM);
            case (p)
                1: l = 19'h7FFFF;                           // beyond the memory size
                2: l = '0;
                3: f = '0;
                4: l = 19'($urandom_range(LK_BASE + 8, LK_MM + 'h200));
                5: begin b = 19'h3FFFF; m = 19'h40000; end
                6: begin b = '0; m = 19'h7FFFF; end
                7: begin b = 19'h7FFFF; m = '0; l = 19'($urandom_range(6, 'h3000)); end
                default: if ($urandom_range(0, 2) == 0) l = 19'($urandom_range(LK_BASE, 'h3000));
            endcase
            write_regs(f, l, b, m);
            calm = (p == NPHASE - 1) || ($urandom_range(0, 3) == 0);
            @(negedge i_clk);
            if (p == 0) begin
                push_query(pick_glyph(1'b0, 1'b0), pick_glyph(1'b0, 1'b1), 1'b0);
                push_query(pick_glyph(1'b1, 1'b0), pick_glyph(1'b1, 1'b1), 1'b1);
                push_query(0, 0, 1'b0);
                push_query(65535, 65535, 1'b1);
            end
            // rebuild a lookup every third phase, alternating between the two
            if (p % 3 == 0) make_lookup(p[0] ? LK_MM : LK_BASE, p[0]);
            for (i = 0; i < 60; i++) begin
                if ($urandom_range(0, 6) == 0) put8($urandom_range('h20000, 'h3FFFF), $urandom);
                else random_query();
            end
            settle();
        end

        repeat (200) @(posedge i_clk);
        if (attach_q.size() != 0) begin
            $error("%0d expected results never arrived", attach_q.size());
            errs++;
        end
        $display("%0d beats in, %0d queries answered, %0d of them attached, %0d register phases",
                 n_items, n_queries, n_hits, NPHASE);
        if (errs == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/mao_pkg.sv
design/mao_if.sv
design/mao_ram.sv
design/mark_attachment_offset_top.sv
dv/tb_top.sv
